/* rtl/lcdfb_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the graphic LCD frame buffer serializer.
// Used by every module of the block; depends on nothing.
package lcdfb_pkg;

  localparam int PIXEL_ROWS    = 64;
  localparam int BYTES_PER_ROW = 16;

  localparam int ROW_W   = $clog2(PIXEL_ROWS);
  localparam int COL_W   = $clog2(BYTES_PER_ROW);
  localparam int FB_DEPTH = PIXEL_ROWS * BYTES_PER_ROW;
  localparam int ADDR_W  = $clog2(FB_DEPTH);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int HALF_ROWS = 32;

  localparam logic [7:0] SYNC_CMD        = 8'hF8;
  localparam logic [7:0] SYNC_DATA       = 8'hFA;
  localparam logic [7:0] NIBBLE_MASK     = 8'hF0;
  localparam logic [7:0] CMD_EXTENDED    = 8'h34;
  localparam logic [7:0] CMD_BASIC       = 8'h30;
  localparam logic [7:0] CMD_GRAPHIC_ON  = 8'h36;
  localparam logic [7:0] ADDR_BASE       = 8'h80;
  localparam logic [7:0] ADDR_LOWER_HALF = 8'h88;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_ROW   = 2'd1,
    KIND_CMD   = 2'd2,
    KIND_DATA  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic       fill;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic        is_data;
    logic [7:0]  byte_sent;
    logic [23:0] serial_word;
    logic        last;
  } frame_t;

  typedef enum logic [1:0] {
    OP_PIX,
    OP_ROW,
    OP_BYTE
  } op_t;

  // One classified item as it sits in the queue between front and back
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
    logic              fill;
    logic [ROW_W-1:0]  row;
    logic              is_data;
    logic [7:0]        byte_value;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX,
    ST_HDR,
    ST_DATA,
    ST_TAIL
  } state_t;

  function automatic frame_t make_frame(input logic is_data, input logic [7:0] b,
                                        input logic last);
    frame_t f;
    f.is_data     = is_data;
    f.byte_sent   = b;
    f.serial_word = {(is_data ? SYNC_DATA : SYNC_CMD), b & NIBBLE_MASK,
                     {b[3:0], 4'h0}};
    f.last        = last;
    return f;
  endfunction

endpackage

/* rtl/lcdfb_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input items, drops out-of-range ones and turns the rest
// into queue commands. Depends on lcdfb_pkg.
module lcdfb_front import lcdfb_pkg::*; (
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  input  logic  q_full,
  output logic  q_push,
  output cmd_t  q_cmd
);

  logic keep;
  logic pix_ok;
  logic row_ok;

  always_comb begin
    pix_ok = (int'(item.x_pos) < 8 * BYTES_PER_ROW) && (int'(item.y_pos) < PIXEL_ROWS);
    row_ok = int'(item.y_pos) < PIXEL_ROWS;

    q_cmd.op         = OP_BYTE;
    q_cmd.addr       = ADDR_W'(int'(item.y_pos) * BYTES_PER_ROW);
    q_cmd.mask       = 8'h80 >> item.x_pos[2:0];
    q_cmd.fill       = item.fill;
    q_cmd.row        = ROW_W'(item.y_pos);
    q_cmd.is_data    = 1'b0;
    q_cmd.byte_value = item.byte_value;
    keep             = 1'b1;

    case (item.kind)
      KIND_PIXEL: begin
        q_cmd.op   = OP_PIX;
        q_cmd.addr = ADDR_W'(int'(item.y_pos) * BYTES_PER_ROW + int'(item.x_pos >> 3));
        keep       = pix_ok;
      end
      KIND_ROW: begin
        q_cmd.op = OP_ROW;
        keep     = row_ok;
      end
      KIND_CMD: begin
        q_cmd.op = OP_BYTE;
      end
      KIND_DATA: begin
        q_cmd.op      = OP_BYTE;
        q_cmd.is_data = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Hold off input during reset; out-of-range items are taken and dropped
  assign item_ready = !q_full && !rst;
  assign q_push     = item_valid && item_ready && keep;

endmodule

/* rtl/lcdfb_queue.sv */
`timescale 1ns / 1ps
// Short command queue between the front and back ends.
// Depends on lcdfb_pkg for the command type and depth.
module lcdfb_queue import lcdfb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = count == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/lcdfb_back.sv */
`timescale 1ns / 1ps
// Back end: owns the frame buffer memory, runs the clearing pass, pixel
// read-modify-write, row refresh sequencing, command/data bytes and the output register. Uses lcdfb_pkg.
module lcdfb_back import lcdfb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       frame_valid,
  input  logic       frame_ready,
  output frame_t     frame,
  output back_stat_t stat
);

  logic [7:0] fb_mem [FB_DEPTH];
  logic [7:0] rd_data;

  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [1:0]        step;
  logic [1:0]        step_next;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] pix_addr;
  logic [7:0]        pix_mask;
  logic              pix_fill;

  logic              out_free;
  logic              load;
  frame_t            load_frame;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic              take_cmd;

  logic [7:0] row8;
  logic       last_row;
  logic       last_col;
  logic       clr_done;
  logic [7:0] hdr_byte;

  assign out_free = !frame_valid || frame_ready;
  assign row8     = 8'(row);
  assign last_row = row == ROW_W'(PIXEL_ROWS - 1);
  assign last_col = col == COL_W'(BYTES_PER_ROW - 1);
  assign clr_done = clr_addr == ADDR_W'(FB_DEPTH - 1);
  assign take_cmd = !q_empty && (head.op != OP_BYTE || out_free);

  always_comb begin
    case (step)
      2'd0:    hdr_byte = CMD_EXTENDED;
      2'd1:    hdr_byte = 8'(ADDR_BASE + (row8 % HALF_ROWS));
      2'd2:    hdr_byte = (int'(row8) < HALF_ROWS) ? ADDR_BASE : ADDR_LOWER_HALF;
      default: hdr_byte = CMD_BASIC;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take_cmd) begin
          case (head.op)
            OP_PIX:  state_next = ST_PIX;
            OP_ROW:  state_next = ST_HDR;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_PIX: begin
        state_next = ST_IDLE;
      end
      ST_HDR: begin
        if (out_free && step == 2'd3) begin
          state_next = ST_DATA;
        end
      end
      ST_DATA: begin
        if (out_free && last_col) begin
          state_next = last_row ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (out_free && step == 2'd1) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Outputs and datapath controls
  always_comb begin
    q_pop      = 1'b0;
    load       = 1'b0;
    load_frame = make_frame(1'b0, CMD_BASIC, 1'b0);
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = row_base + ADDR_W'(col);
    mem_wdata  = 8'h00;
    step_next  = step;
    col_next   = col;
    case (state)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      ST_IDLE: begin
        step_next = 2'd0;
        if (take_cmd) begin
          q_pop = 1'b1;
          case (head.op)
            OP_PIX: begin
              mem_re   = 1'b1;
              mem_addr = head.addr;
            end
            OP_BYTE: begin
              load       = 1'b1;
              load_frame = make_frame(head.is_data, head.byte_value, 1'b1);
            end
            default: begin
            end
          endcase
        end
      end
      ST_PIX: begin
        mem_we    = 1'b1;
        mem_addr  = pix_addr;
        mem_wdata = pix_fill ? (rd_data | pix_mask) : (rd_data & ~pix_mask);
      end
      ST_HDR: begin
        if (out_free) begin
          load       = 1'b1;
          load_frame = make_frame(1'b0, hdr_byte, 1'b0);
          step_next  = step + 2'd1;
          if (step == 2'd3) begin
            // Prefetch the first buffer byte of the row
            mem_re   = 1'b1;
            mem_addr = row_base;
            col_next = '0;
          end
        end
      end
      ST_DATA: begin
        step_next = 2'd0;
        if (out_free) begin
          load       = 1'b1;
          load_frame = make_frame(1'b1, rd_data, last_col && !last_row);
          if (!last_col) begin
            mem_re   = 1'b1;
            mem_addr = row_base + ADDR_W'(col) + ADDR_W'(1);
            col_next = col + COL_W'(1);
          end
        end
      end
      ST_TAIL: begin
        if (out_free) begin
          load       = 1'b1;
          load_frame = make_frame(1'b0, (step == 2'd0) ? CMD_GRAPHIC_ON : CMD_BASIC,
                                  step == 2'd1);
          step_next  = step + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fb_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= fb_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      step        <= '0;
      col         <= '0;
      frame_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      col   <= col_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (load) begin
        frame_valid <= 1'b1;
      end else if (frame_ready) begin
        frame_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame <= load_frame;
    end
    if (q_pop) begin
      row      <= head.row;
      row_base <= head.addr;
      pix_addr <= head.addr;
      pix_mask <= head.mask;
      pix_fill <= head.fill;
    end
  end

  assign stat.clearing = state == ST_CLEAR;

endmodule

/* rtl/graphic_lcd_framebuffer_serializer.sv */
`timescale 1ns / 1ps
// Top level of the graphic LCD frame buffer serializer: front end, command
// queue and back end. Depends on lcdfb_pkg, lcdfb_front, lcdfb_queue, lcdfb_back.
//
//   channel  handshake                payload
//   input    item_valid / item_ready  item  (item_t: kind, x_pos, y_pos, fill, byte_value)
//   output   frame_valid / frame_ready frame (frame_t: is_data, byte_sent, serial_word, last)
//
// After reset the back end sweeps all 1024 frame buffer bytes to zero, one byte a cycle;
// up to two items queue meanwhile, no frame leaves.
// Pixel write: memory read on dispatch, then write. Command or data byte: loaded on
// dispatch. Row refresh: a dispatch, then one frame a cycle unless the output stalls
// (20 frames, or 22 for the last row), paced by the single frame buffer port and output
// register. A stalled output holds the back end once it has a frame to send; pixel
// writes ahead of that still complete, and the front keeps filling the queue.
module graphic_lcd_framebuffer_serializer import lcdfb_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  output logic   item_ready,
  input  item_t  item,
  output logic   frame_valid,
  input  logic   frame_ready,
  output frame_t frame
);

  logic       q_full;
  logic       q_empty;
  logic       q_push;
  logic       q_pop;
  cmd_t       q_cmd;
  cmd_t       q_head;
  back_stat_t stat;

  lcdfb_front u_front (
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  lcdfb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  lcdfb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .stat        (stat)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("push into full command queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty command queue");

  a_quiet_clear: assert property (@(posedge clk) disable iff (rst)
    stat.clearing |-> !frame_valid && !q_pop)
    else $error("frame or dispatch during clearing pass");

  a_frame_form: assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> (frame.serial_word[23:16] == (frame.is_data ? SYNC_DATA : SYNC_CMD))
                    && (frame.serial_word[15:8] == (frame.byte_sent & NIBBLE_MASK))
                    && (frame.serial_word[7:0] == {frame.byte_sent[3:0], 4'h0}))
    else $error("malformed serial frame");

endmodule
